// ===== design/lsps_pkg.sv =====
// Shared types and constants for the least-served process scheduler.
package lsps_pkg;

  // Field widths fixed by the interface.
  localparam int CMD_W         = 1;
  localparam int SLOT_W        = 4;
  localparam int ARRIVAL_W     = 16;
  localparam int SLICES_W      = 16;
  localparam int SERVED_W      = 16;
  localparam int SLICE_LEN_W   = 8;
  localparam int SLICE_START_W = 16;

  // Defaults for the top-level parameters.
  localparam int MAX_PROCESSES_DEF = 16;
  localparam int TIME_WIDTH_DEF    = 16;

  // Reset value of the slice length register.
  localparam logic [SLICE_LEN_W-1:0] SLICE_LEN_RST = SLICE_LEN_W'(1);

  // Request command codes.
  localparam logic [CMD_W-1:0] CMD_ADD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

  // One process entry as held in the table memory.
  typedef struct packed {
    logic [ARRIVAL_W-1:0] arrival;
    logic [SLICES_W-1:0]  remaining;
    logic [SERVED_W-1:0]  served;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } state_t;

endpackage

// ===== design/lsps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lsps_ram #(
  parameter int WIDTH = lsps_pkg::ENTRY_W,
  parameter int DEPTH = lsps_pkg::MAX_PROCESSES_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/least_served_process_scheduler_top.sv =====
// Top level of the least-served process scheduler with its scan sequencer.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-----------------------------------------
//  cfg     | in        | cfg_wr_en            | cfg_wr_data (slice length)
//  in      | in        | in_valid / in_stall  | command, slot, arrival_time, service_slices
//  out     | out       | out_valid / out_stall| granted, granted_slot, finished, slice_start
//
// An add request is accepted in the idle state. A tick request scans the table from its
// accept, one entry per scan step through the single memory read port, then passes the
// last-compare state and the finish state, which writes back the grant and loads the result,
// and returns to the idle state that takes the next request.
// Reset (rst_n, synchronous, active low) clears the valid bits, time and control state.
// A stalled result holds in the output register; add requests are still taken meanwhile,
// and a finished tick waits in its last state until the output register frees.
module least_served_process_scheduler_top #(
  parameter int MAX_PROCESSES = lsps_pkg::MAX_PROCESSES_DEF,
  parameter int TIME_WIDTH    = lsps_pkg::TIME_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration port
  input  logic                                 cfg_wr_en,
  input  logic [lsps_pkg::SLICE_LEN_W-1:0]     cfg_wr_data,
  // Request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [lsps_pkg::CMD_W-1:0]           in_command,
  input  logic [lsps_pkg::SLOT_W-1:0]          in_slot,
  input  logic [lsps_pkg::ARRIVAL_W-1:0]       in_arrival_time,
  input  logic [lsps_pkg::SLICES_W-1:0]        in_service_slices,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_granted,
  output logic [lsps_pkg::SLOT_W-1:0]          out_granted_slot,
  output logic                                 out_finished,
  output logic [lsps_pkg::SLICE_START_W-1:0]   out_slice_start
);

  localparam int IDX_W    = $clog2(MAX_PROCESSES);
  localparam int TS_W     = TIME_WIDTH + 1;
  localparam int CMP_W    = (TIME_WIDTH > lsps_pkg::ARRIVAL_W) ? TIME_WIDTH
                                                                : lsps_pkg::ARRIVAL_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCESSES - 1);
  localparam logic [lsps_pkg::SLICE_START_W-1:0] START_MAX = '1;
  localparam logic [lsps_pkg::SERVED_W-1:0]      SERVED_MAX = '1;
  localparam logic [TIME_WIDTH-1:0]              TIME_MAX = '1;

  lsps_pkg::state_t state_r, state_nxt;

  logic [lsps_pkg::SLICE_LEN_W-1:0] slice_len_r;
  logic [TIME_WIDTH-1:0]            cur_time_r;
  logic [MAX_PROCESSES-1:0]         valid_r;

  logic [IDX_W-1:0]                 addr_r;
  logic                             cmp_vld_r;
  logic [IDX_W-1:0]                 cmp_idx_r;
  logic                             vbit_r;

  logic                             best_found_r;
  logic [IDX_W-1:0]                 best_idx_r;
  lsps_pkg::entry_t                 best_ent_r;

  logic                             out_valid_r;
  logic                             out_granted_r;
  logic [lsps_pkg::SLOT_W-1:0]      out_granted_slot_r;
  logic                             out_finished_r;
  logic [lsps_pkg::SLICE_START_W-1:0] out_slice_start_r;

  logic                             in_accept;
  logic                             add_go;
  logic                             tick_go;
  logic                             slot_ok;
  logic                             fin_go;
  logic                             scan_en;

  logic                             ram_we;
  logic [IDX_W-1:0]                 ram_waddr;
  lsps_pkg::entry_t                 ram_wdata;
  lsps_pkg::entry_t                 ram_rdata;

  lsps_pkg::entry_t                 add_ent;
  lsps_pkg::entry_t                 grant_ent;
  logic                             eligible;
  logic                             better;
  logic [TS_W-1:0]                  time_sum;
  logic [TIME_WIDTH-1:0]            time_next;
  logic [CMP_W-1:0]                 time_ext;
  logic [lsps_pkg::SLICE_START_W-1:0] start_sat;

  // Request decode.
  assign in_accept = in_valid && !in_stall;
  assign slot_ok   = (32'(in_slot) < MAX_PROCESSES);
  assign add_go    = in_accept && (in_command == lsps_pkg::CMD_ADD) && slot_ok;
  assign tick_go   = in_accept && (in_command == lsps_pkg::CMD_TICK);

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lsps_pkg::ST_IDLE: begin
        if (tick_go) state_nxt = lsps_pkg::ST_SCAN;
      end
      lsps_pkg::ST_SCAN: begin
        if (addr_r == LAST_IDX) state_nxt = lsps_pkg::ST_LAST;
      end
      lsps_pkg::ST_LAST: begin
        state_nxt = lsps_pkg::ST_FINISH;
      end
      lsps_pkg::ST_FINISH: begin
        if (fin_go) state_nxt = lsps_pkg::ST_IDLE;
      end
      default: state_nxt = lsps_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall = 1'b1;
    scan_en  = 1'b0;
    fin_go   = 1'b0;
    unique case (state_r)
      lsps_pkg::ST_IDLE:   in_stall = 1'b0;
      lsps_pkg::ST_SCAN:   scan_en  = 1'b1;
      lsps_pkg::ST_LAST:   scan_en  = 1'b0;
      lsps_pkg::ST_FINISH: fin_go   = !out_valid_r || !out_stall;
      default:             in_stall = 1'b1;
    endcase
  end

  // Entries written by an add and by a grant.
  always_comb begin
    add_ent.arrival   = in_arrival_time;
    add_ent.remaining = in_service_slices;
    add_ent.served    = '0;
    grant_ent.arrival   = best_ent_r.arrival;
    grant_ent.remaining = best_ent_r.remaining - lsps_pkg::SLICES_W'(1);
    grant_ent.served    = (best_ent_r.served == SERVED_MAX) ? best_ent_r.served
                        : best_ent_r.served + lsps_pkg::SERVED_W'(1);
  end

  // Memory write port: adds in idle, the grant write-back when the tick finishes.
  assign ram_we    = add_go || (fin_go && best_found_r);
  assign ram_waddr = add_go ? IDX_W'(in_slot) : best_idx_r;
  assign ram_wdata = add_go ? add_ent : grant_ent;

  lsps_ram #(
    .WIDTH (lsps_pkg::ENTRY_W),
    .DEPTH (MAX_PROCESSES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (addr_r),
    .rd_data (ram_rdata)
  );

  // Eligibility and least-served compare on the entry returned from memory.
  assign eligible = cmp_vld_r && vbit_r && (ram_rdata.remaining != '0) &&
                    (CMP_W'(ram_rdata.arrival) <= CMP_W'(cur_time_r));
  assign better   = eligible && (!best_found_r || (ram_rdata.served < best_ent_r.served));

  // Time advance with saturation, and the saturated slice start.
  assign time_sum  = TS_W'(cur_time_r) + TS_W'(slice_len_r);
  assign time_next = time_sum[TIME_WIDTH] ? TIME_MAX : time_sum[TIME_WIDTH-1:0];
  assign time_ext  = CMP_W'(cur_time_r);
  assign start_sat = (time_ext > CMP_W'(START_MAX)) ? START_MAX
                   : time_ext[lsps_pkg::SLICE_START_W-1:0];

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lsps_pkg::ST_IDLE;
      slice_len_r  <= lsps_pkg::SLICE_LEN_RST;
      cur_time_r   <= '0;
      valid_r      <= '0;
      addr_r       <= '0;
      cmp_vld_r    <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= scan_en;
      if (cfg_wr_en) begin
        slice_len_r <= cfg_wr_data;
      end
      if (add_go) begin
        valid_r[IDX_W'(in_slot)] <= 1'b1;
      end
      if (tick_go) begin
        addr_r       <= '0;
        best_found_r <= 1'b0;
      end else begin
        if (scan_en && (addr_r != LAST_IDX)) begin
          addr_r <= addr_r + IDX_W'(1);
        end
        if (better) begin
          best_found_r <= 1'b1;
        end
      end
      if (fin_go) begin
        cur_time_r  <= time_next;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan pipeline and result payload registers.
  always_ff @(posedge clk) begin
    cmp_idx_r <= addr_r;
    vbit_r    <= valid_r[addr_r];
    if (better) begin
      best_idx_r <= cmp_idx_r;
      best_ent_r <= ram_rdata;
    end
    if (fin_go) begin
      out_granted_r      <= best_found_r;
      out_granted_slot_r <= best_found_r ? lsps_pkg::SLOT_W'(best_idx_r) : '0;
      out_finished_r     <= best_found_r && (grant_ent.remaining == '0);
      out_slice_start_r  <= start_sat;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted      = out_granted_r;
  assign out_granted_slot = out_granted_slot_r;
  assign out_finished     = out_finished_r;
  assign out_slice_start  = out_slice_start_r;

  // A finishing tick always leaves a result in the output register.
  assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r)
    else $error("finished tick did not load a result");

  // An idle result carries no slot and no completion.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_granted_r) |-> (!out_finished_r && (out_granted_slot_r == '0)))
    else $error("idle result carries grant data");

  // Time never runs backwards outside reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (cur_time_r >= $past(cur_time_r)))
    else $error("current time decreased");

  // A chosen process is always a slot that has been loaded.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == lsps_pkg::ST_FINISH) && best_found_r) |-> valid_r[best_idx_r])
    else $error("grant selected an unloaded slot");

  // Time only moves when a tick completes.
  assert property (@(posedge clk) disable iff (!rst_n)
    !fin_go |=> $stable(cur_time_r))
    else $error("current time changed outside a tick");

endmodule
